// ===== rtl/core/iqpe_pkg.sv =====
package iqpe_pkg;

    // Ring geometry.
    localparam int QUEUE_DEPTH = 64;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Field widths fixed by the interface.
    localparam int SLOT_W     = 6;
    localparam int DB_OFF_W   = 19;
    localparam int CID_W      = 16;
    localparam int COUNT_W    = 16;
    localparam int ADDR_W     = 64;
    localparam int STATUS_W   = 16;
    localparam int OUTCOME_W  = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    // Doorbell layout.
    localparam logic [DB_OFF_W-1:0] DB_BASE   = DB_OFF_W'(32'h1000);
    localparam logic [DB_OFF_W-1:0] DB_STRIDE = DB_OFF_W'(4);

    // Opcodes.
    localparam logic [7:0] OPC_WRITE = 8'h01;
    localparam logic [7:0] OPC_READ  = 8'h02;

    // Item kinds.
    localparam logic FUNC_SUBMIT   = 1'b0;
    localparam logic FUNC_COMPLETE = 1'b1;

    // Outcome codes.
    localparam logic [OUTCOME_W-1:0] OUT_REJECTED    = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_POSTED      = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_NOT_PRESENT = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_DONE_OK     = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_DONE_ERROR  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROLLER_READY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_MAP_BASE  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DB_STRIDE_CODE   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SECTORS      = 4'd3;

    localparam logic [COUNT_W-1:0] MAX_SECTORS_RESET = 16'd8;

    typedef struct packed {
        logic                controller_ready;
        logic [ADDR_W-1:0]   direct_map_base;
        logic [3:0]          doorbell_stride_code;
        logic [COUNT_W-1:0]  max_sectors;
    } cfg_t;

    typedef struct packed {
        logic                func;
        logic                is_write;
        logic [63:0]         start_lba;
        logic [COUNT_W-1:0]  sector_count;
        logic [ADDR_W-1:0]   buffer_virt;
        logic [STATUS_W-1:0] completion_status;
    } req_t;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [SLOT_W-1:0]    sq_slot;
        logic [31:0]          command_word0;
        logic [ADDR_W-1:0]    data_pointer;
        logic [31:0]          lba_low_word;
        logic [31:0]          lba_high_word;
        logic [COUNT_W-1:0]   blocks_minus_one;
        logic [DB_OFF_W-1:0]  doorbell_offset;
        logic [SLOT_W-1:0]    doorbell_value;
    } rsp_t;

    // Input register contents handed to the execute logic.
    typedef struct packed {
        logic valid;
        req_t item;
    } stage_t;

endpackage

// ===== rtl/core/iqpe_if.sv =====
interface iqpe_req_if;
    logic                             valid;
    logic                             ready;
    logic                             func;
    logic                             is_write;
    logic [63:0]                      start_lba;
    logic [iqpe_pkg::COUNT_W-1:0]     sector_count;
    logic [iqpe_pkg::ADDR_W-1:0]      buffer_virt;
    logic [iqpe_pkg::STATUS_W-1:0]    completion_status;

    modport source (
        output valid, func, is_write, start_lba, sector_count, buffer_virt,
               completion_status,
        input  ready
    );
    modport sink (
        input  valid, func, is_write, start_lba, sector_count, buffer_virt,
               completion_status,
        output ready
    );
endinterface

interface iqpe_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [iqpe_pkg::OUTCOME_W-1:0]   outcome;
    logic [iqpe_pkg::SLOT_W-1:0]      sq_slot;
    logic [31:0]                      command_word0;
    logic [iqpe_pkg::ADDR_W-1:0]      data_pointer;
    logic [31:0]                      lba_low_word;
    logic [31:0]                      lba_high_word;
    logic [iqpe_pkg::COUNT_W-1:0]     blocks_minus_one;
    logic [iqpe_pkg::DB_OFF_W-1:0]    doorbell_offset;
    logic [iqpe_pkg::SLOT_W-1:0]      doorbell_value;

    modport source (
        output valid, outcome, sq_slot, command_word0, data_pointer, lba_low_word,
               lba_high_word, blocks_minus_one, doorbell_offset, doorbell_value,
        input  ready
    );
    modport sink (
        input  valid, outcome, sq_slot, command_word0, data_pointer, lba_low_word,
               lba_high_word, blocks_minus_one, doorbell_offset, doorbell_value,
        output ready
    );
endinterface

interface iqpe_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [iqpe_pkg::CFG_IDX_W-1:0]   index;
    logic [iqpe_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/io_queue_pair_engine_top.sv =====
// Channel  Dir  Role
// req      in   submit requests and observed completion entries
// rsp      out  one result item per request item
// cfg      in   register writes (index, data); always ready
//
// Each item passes an input register and then a result register; one item per
// cycle is sustained while rsp is ready. Queue pointers, phase and command id
// update when an item moves from the input register into the result register.
// Reset (rst_n low, asynchronous) empties both registers and restores the
// queue state and configuration defaults. A stalled result holds the input
// register; an item is still taken while the result register is being drained.
module io_queue_pair_engine_top (
    input  logic        clk,
    input  logic        rst_n,
    iqpe_req_if.sink    req,
    iqpe_rsp_if.source  rsp,
    iqpe_cfg_if.sink    cfg
);

    iqpe_pkg::cfg_t    regs;
    iqpe_pkg::stage_t  stage;
    iqpe_pkg::rsp_t    result;
    logic              advance;

    iqpe_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    iqpe_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .advance (advance),
        .stage   (stage)
    );

    iqpe_exec u_exec (
        .clk     (clk),
        .rst_n   (rst_n),
        .regs    (regs),
        .stage   (stage),
        .advance (advance),
        .result  (result)
    );

    iqpe_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (stage.valid),
        .result     (result),
        .advance    (advance),
        .rsp        (rsp)
    );

endmodule

// ===== rtl/core/iqpe_cfg_regs.sv =====
module iqpe_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    iqpe_cfg_if.sink         cfg,
    output iqpe_pkg::cfg_t   regs
);

    iqpe_pkg::cfg_t regs_reg;
    iqpe_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                iqpe_pkg::CFG_CONTROLLER_READY:
                    regs_next.controller_ready = cfg.data[0];
                iqpe_pkg::CFG_DIRECT_MAP_BASE:
                    regs_next.direct_map_base = cfg.data;
                iqpe_pkg::CFG_DB_STRIDE_CODE:
                    regs_next.doorbell_stride_code = cfg.data[3:0];
                iqpe_pkg::CFG_MAX_SECTORS:
                    regs_next.max_sectors = cfg.data[iqpe_pkg::COUNT_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.controller_ready     <= 1'b0;
            regs_reg.direct_map_base      <= '0;
            regs_reg.doorbell_stride_code <= 4'd0;
            regs_reg.max_sectors          <= iqpe_pkg::MAX_SECTORS_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== rtl/core/iqpe_in_stage.sv =====
module iqpe_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    iqpe_req_if.sink           req,
    input  logic               advance,
    output iqpe_pkg::stage_t   stage
);

    logic            valid_reg;
    logic            valid_next;
    iqpe_pkg::req_t  item_reg;
    logic            load;

    // The register can take a new item when empty or when its item moves on.
    assign req.ready  = !valid_reg || advance;
    assign load       = req.valid && req.ready;
    assign valid_next = load || (valid_reg && !advance);

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.func              <= req.func;
            item_reg.is_write          <= req.is_write;
            item_reg.start_lba         <= req.start_lba;
            item_reg.sector_count      <= req.sector_count;
            item_reg.buffer_virt       <= req.buffer_virt;
            item_reg.completion_status <= req.completion_status;
        end
    end

endmodule

// ===== rtl/core/iqpe_exec.sv =====
module iqpe_exec (
    input  logic               clk,
    input  logic               rst_n,
    input  iqpe_pkg::cfg_t     regs,
    input  iqpe_pkg::stage_t   stage,
    input  logic               advance,
    output iqpe_pkg::rsp_t     result
);

    logic [iqpe_pkg::QPTR_W-1:0] sq_tail_reg, sq_tail_next;
    logic [iqpe_pkg::QPTR_W-1:0] cq_head_reg, cq_head_next;
    logic                        cq_phase_reg, cq_phase_next;
    logic [iqpe_pkg::CID_W-1:0]  cid_reg, cid_next;

    logic                             fire;
    logic                             reject;
    logic                             present;
    logic [iqpe_pkg::QPTR_W-1:0]      tail_inc;
    logic [iqpe_pkg::QPTR_W-1:0]      head_inc;
    logic [iqpe_pkg::DB_OFF_W-1:0]    stride;
    logic [iqpe_pkg::DB_OFF_W-1:0]    sq_db_off;
    logic [iqpe_pkg::DB_OFF_W-1:0]    cq_db_off;
    iqpe_pkg::req_t                   it;

    localparam logic [iqpe_pkg::QPTR_W-1:0] LAST_SLOT =
        iqpe_pkg::QPTR_W'(iqpe_pkg::QUEUE_DEPTH - 1);

    assign it   = stage.item;
    assign fire = stage.valid && advance;

    assign tail_inc = (sq_tail_reg == LAST_SLOT) ? '0 : sq_tail_reg + 1'b1;
    assign head_inc = (cq_head_reg == LAST_SLOT) ? '0 : cq_head_reg + 1'b1;

    // Submission doorbell is queue index 2, completion doorbell index 3.
    assign stride    = iqpe_pkg::DB_STRIDE << regs.doorbell_stride_code;
    assign sq_db_off = iqpe_pkg::DB_BASE + (stride << 1);
    assign cq_db_off = iqpe_pkg::DB_BASE + (stride << 1) + stride;

    assign reject  = !regs.controller_ready || (it.sector_count == '0)
                     || (it.sector_count > regs.max_sectors);
    assign present = regs.controller_ready
                     && (it.completion_status[0] == cq_phase_reg);

    always_comb
    begin
        result        = '0;
        sq_tail_next  = sq_tail_reg;
        cq_head_next  = cq_head_reg;
        cq_phase_next = cq_phase_reg;
        cid_next      = cid_reg;

        case (it.func)
            iqpe_pkg::FUNC_SUBMIT:
            begin
                if (reject)
                begin
                    result.outcome = iqpe_pkg::OUT_REJECTED;
                end
                else
                begin
                    result.outcome          = iqpe_pkg::OUT_POSTED;
                    result.sq_slot          = iqpe_pkg::SLOT_W'(sq_tail_reg);
                    result.command_word0    = {cid_reg, 8'h00,
                        (it.is_write ? iqpe_pkg::OPC_WRITE : iqpe_pkg::OPC_READ)};
                    result.data_pointer     = it.buffer_virt - regs.direct_map_base;
                    result.lba_low_word     = it.start_lba[31:0];
                    result.lba_high_word    = it.start_lba[63:32];
                    result.blocks_minus_one = it.sector_count - 1'b1;
                    result.doorbell_offset  = sq_db_off;
                    result.doorbell_value   = iqpe_pkg::SLOT_W'(tail_inc);
                    sq_tail_next            = tail_inc;
                    cid_next                = cid_reg + 1'b1;
                end
            end
            iqpe_pkg::FUNC_COMPLETE:
            begin
                if (!present)
                begin
                    result.outcome = iqpe_pkg::OUT_NOT_PRESENT;
                end
                else
                begin
                    // Status code is bits 11:1; the upper nibble is ignored.
                    result.outcome = (it.completion_status[11:1] == '0)
                                     ? iqpe_pkg::OUT_DONE_OK
                                     : iqpe_pkg::OUT_DONE_ERROR;
                    result.doorbell_offset = cq_db_off;
                    result.doorbell_value  = iqpe_pkg::SLOT_W'(head_inc);
                    cq_head_next           = head_inc;
                    if (head_inc == '0)
                    begin
                        cq_phase_next = !cq_phase_reg;
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_tail_reg  <= '0;
            cq_head_reg  <= '0;
            cq_phase_reg <= 1'b1;
            cid_reg      <= '0;
        end
        else if (fire)
        begin
            sq_tail_reg  <= sq_tail_next;
            cq_head_reg  <= cq_head_next;
            cq_phase_reg <= cq_phase_next;
            cid_reg      <= cid_next;
        end
    end

endmodule

// ===== rtl/core/iqpe_out_stage.sv =====
module iqpe_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load_valid,
    input  iqpe_pkg::rsp_t   result,
    output logic             advance,
    iqpe_rsp_if.source       rsp
);

    logic            valid_reg;
    logic            valid_next;
    iqpe_pkg::rsp_t  data_reg;
    logic            load;

    // The result register takes a new item when empty or being drained.
    assign advance    = !valid_reg || rsp.ready;
    assign load       = load_valid && advance;
    assign valid_next = load || (valid_reg && !rsp.ready);

    assign rsp.valid            = valid_reg;
    assign rsp.outcome          = data_reg.outcome;
    assign rsp.sq_slot          = data_reg.sq_slot;
    assign rsp.command_word0    = data_reg.command_word0;
    assign rsp.data_pointer     = data_reg.data_pointer;
    assign rsp.lba_low_word     = data_reg.lba_low_word;
    assign rsp.lba_high_word    = data_reg.lba_high_word;
    assign rsp.blocks_minus_one = data_reg.blocks_minus_one;
    assign rsp.doorbell_offset  = data_reg.doorbell_offset;
    assign rsp.doorbell_value   = data_reg.doorbell_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

endmodule
